// File: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_code_t          command;
    logic [KEY_W-1:0]   key;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   popped_key;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic    push_en;
    logic    pop_en;
    logic    load_res;
    status_t res_status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } fsm_state_t;

endpackage
`default_nettype wire

// File: rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts items, decides the status code and issues
// push, pop and result-load commands to the datapath.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire spq_pkg::cmd_code_t in_command,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire spq_pkg::dp_stat_t  dp_stat,
  output spq_pkg::ctrl_cmd_t      cmd
);

  spq_pkg::fsm_state_t state_r;
  spq_pkg::fsm_state_t state_nxt;
  logic                accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_stall       = 1'b0;
    out_valid      = 1'b0;
    state_nxt      = state_r;
    cmd.push_en    = 1'b0;
    cmd.pop_en     = 1'b0;
    cmd.res_status = spq_pkg::ST_OK;

    case (state_r)
      spq_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      spq_pkg::S_HOLD: begin
        out_valid = 1'b1;
        // hold the input while the waiting item is not taken
        in_stall  = out_stall;
        if (!out_stall) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase

    accept       = in_valid && !in_stall;
    cmd.load_res = accept;

    case (in_command)
      spq_pkg::CMD_PUSH: begin
        if (dp_stat.full) begin
          cmd.res_status = spq_pkg::ST_FULL;
        end else begin
          cmd.push_en = accept;
        end
      end
      spq_pkg::CMD_POP: begin
        if (dp_stat.empty) begin
          cmd.res_status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.pop_en = accept;
        end
      end
      default: begin
        cmd.res_status = spq_pkg::ST_OK;
      end
    endcase

    if (accept) begin
      state_nxt = spq_pkg::S_HOLD;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Row of key cells kept in ascending order, the entry counter and the
// result register. Each cell compares against the incoming key on its own.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [spq_pkg::KEY_W-1:0]     in_key,
  input  wire spq_pkg::ctrl_cmd_t            cmd,
  output spq_pkg::dp_stat_t                  dp_stat,
  output spq_pkg::out_item_t                 res
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [KEY_BITS-1:0]                    cell_r   [DEPTH];
  logic [KEY_BITS-1:0]                    cell_nxt [DEPTH];
  logic [DEPTH-1:0]                       occ;
  logic [DEPTH-1:0]                       lt;
  logic [CNT_W-1:0]                       count_r;
  logic [CNT_W-1:0]                       count_nxt;
  logic [KEY_BITS+spq_pkg::KEY_W-1:0]     key_wide;
  logic [KEY_BITS-1:0]                    key_in;
  logic [KEY_BITS+spq_pkg::KEY_W-1:0]     head_wide;
  logic [CNT_W+spq_pkg::OCC_W-1:0]        occ_wide;
  spq_pkg::out_item_t                     res_r;
  spq_pkg::out_item_t                     res_nxt;

  // reduce or zero-extend the port key to the stored width
  assign key_wide = {{KEY_BITS{1'b0}}, in_key};
  assign key_in   = key_wide[KEY_BITS-1:0];

  assign dp_stat.full  = (count_r == CNT_W'(DEPTH));
  assign dp_stat.empty = (count_r == '0);

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count_r);
      assign lt[i]  = occ[i] && (cell_r[i] < key_in);

      always_comb begin
        cell_nxt[i] = cell_r[i];
        if (cmd.push_en) begin
          if (i == 0) begin
            if (!lt[i]) begin
              cell_nxt[i] = key_in;
            end
          end else begin
            if (!lt[i]) begin
              cell_nxt[i] = lt[(i == 0) ? 0 : i-1] ? key_in : cell_r[(i == 0) ? 0 : i-1];
            end
          end
        end else if (cmd.pop_en) begin
          if (i < DEPTH-1) begin
            cell_nxt[i] = cell_r[(i < DEPTH-1) ? i+1 : i];
          end
        end
      end

      always_ff @(posedge clk) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.push_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_wide = {{spq_pkg::KEY_W{1'b0}}, cell_r[0]};
  assign occ_wide  = {{spq_pkg::OCC_W{1'b0}}, count_nxt};

  always_comb begin
    res_nxt            = res_r;
    if (cmd.load_res) begin
      res_nxt.status     = cmd.res_status;
      res_nxt.popped_key = cmd.pop_en ? head_wide[spq_pkg::KEY_W-1:0] : '0;
      res_nxt.occupancy  = occ_wide[spq_pkg::OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// File: rtl/core/sorted_insert_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Priority queue of up to DEPTH unsigned keys held in ascending order.
// ----------------------------------------------------------------------------
// A push inserts its key ahead of any equal keys; a pop returns the smallest
// key. Every item gives one result carrying a status code and the occupancy
// after the operation. One item is taken per clock: all cells compare
// against the incoming key in parallel and shift in the same cycle, and the
// result appears in the output register the cycle after the item is
// accepted. While that result is stalled the input is stalled too, so the
// rate is one item per cycle whenever the output side takes results freely.
// No clearing pass follows reset; the block is ready at once.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire spq_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output spq_pkg::out_item_t       out_data
);

  spq_pkg::ctrl_cmd_t cmd;
  spq_pkg::dp_stat_t  dp_stat;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dp_stat    (dp_stat),
    .cmd        (cmd)
  );

  spq_datapath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_key  (in_data.key),
    .cmd     (cmd),
    .dp_stat (dp_stat),
    .res     (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/core/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH = 16
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire spq_pkg::out_item_t out_data
);

  localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = spq_pkg::OCC_W'(DEPTH);

  // drop no item: nothing enters while a result is blocked
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("item accepted while result stalled");

  // every accepted item shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == spq_pkg::ST_FULL |->
      out_data.occupancy == FULL_OCC && out_data.popped_key == '0)
    else $error("rejected push with wrong occupancy");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == spq_pkg::ST_EMPTY |->
      out_data.occupancy == '0 && out_data.popped_key == '0)
    else $error("pop on empty with wrong result");

endmodule

bind sorted_insert_priority_queue spq_checker #(
  .DEPTH (DEPTH)
) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted-insert priority queue.
// A clocked driver feeds push and pop items from a pending queue in bursts
// with gaps. A shadow sorted store predicts status, popped key and occupancy
// for every accepted item. A clocked monitor takes results under a changing
// stall pattern, with long hold-offs, and checks them in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 32;
  localparam int RANDOM_ITEMS = 530;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam logic [spq_pkg::KEY_W-1:0] KEY_MASK =
    {spq_pkg::KEY_W{1'b1}} >> (spq_pkg::KEY_W - KEY_BITS);

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               out_stall = 1'b0;
  spq_pkg::in_item_t  in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  spq_pkg::out_item_t out_data;

  spq_pkg::in_item_t  pending_items[$];
  spq_pkg::out_item_t expected_results[$];

  // shadow of the sorted store
  logic [spq_pkg::KEY_W-1:0] shadow_keys[DEPTH];
  int                        shadow_count = 0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;

  sorted_insert_priority_queue #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic spq_pkg::in_item_t make_item(spq_pkg::cmd_code_t cmd,
                                                  logic [spq_pkg::KEY_W-1:0] key);
    spq_pkg::in_item_t item;
    item.command = cmd;
    item.key     = key;
    return item;
  endfunction

  // Apply one item to the shadow store and return the result it should give.
  function automatic spq_pkg::out_item_t predict_queue_op(spq_pkg::in_item_t item);
    spq_pkg::out_item_t        res;
    logic [spq_pkg::KEY_W-1:0] key;
    int                        pos;
    res.status     = spq_pkg::ST_OK;
    res.popped_key = '0;
    key            = item.key & KEY_MASK;
    if (item.command == spq_pkg::CMD_PUSH) begin
      if (shadow_count >= DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // new key goes ahead of equal keys
        pos = 0;
        while (pos < shadow_count && key > shadow_keys[pos]) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[pos] = key;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.popped_key = shadow_keys[0];
        for (int i = 1; i < shadow_count; i++) shadow_keys[i-1] = shadow_keys[i];
        shadow_count--;
      end
    end
    res.occupancy = spq_pkg::OCC_W'(shadow_count);
    return res;
  endfunction

  function automatic logic [spq_pkg::KEY_W-1:0] random_key();
    case ($urandom_range(3))
      0:       return spq_pkg::KEY_W'($urandom_range(7));
      1:       return spq_pkg::KEY_W'($urandom);
      2:       return {spq_pkg::KEY_W{1'b1}} - spq_pkg::KEY_W'($urandom_range(7));
      default: return spq_pkg::KEY_W'($urandom) & spq_pkg::KEY_W'($urandom);
    endcase
  endfunction

  // Sender: bursts of random length, random gaps between them.
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_queue_op(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall mode is redrawn whenever its timer runs out; two long hold-offs on top.
  int stall_mode  = 0;
  int mode_timer  = 0;
  int hold_left   = 0;
  int holds_taken = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if ((holds_taken == 0 && results_seen >= 150 && in_valid) ||
                 (holds_taken == 1 && results_seen >= 420 && in_valid)) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      holds_taken <= holds_taken + 1;
    end else begin
      if (mode_timer == 0) begin
        stall_mode <= $urandom_range(3);
        mode_timer <= 49;
      end else begin
        mode_timer <= mode_timer - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(3) == 0);
        2:       out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= (mode_timer % 3 == 0);
      endcase
    end
  end

  // Monitor: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    spq_pkg::out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: status=%0d popped=%h occupancy=%0d",
                   out_data.status, out_data.popped_key, out_data.occupancy);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.status !== exp_res.status ||
            out_data.popped_key !== exp_res.popped_key ||
            out_data.occupancy !== exp_res.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: expected status=%0d popped=%h occupancy=%0d,",
                      " got status=%0d popped=%h occupancy=%0d"},
                     exp_res.status, exp_res.popped_key, exp_res.occupancy,
                     out_data.status, out_data.popped_key, out_data.occupancy);
        end
      end
    end
  end

  // Cycle limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int push_pct;
    // pop on empty with a key that must be ignored
    pending_items.push_back(make_item(spq_pkg::CMD_POP, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(spq_pkg::CMD_PUSH, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(spq_pkg::CMD_PUSH, 32'h0000_0000));
    pending_items.push_back(make_item(spq_pkg::CMD_PUSH, 32'h0000_0000));
    pending_items.push_back(make_item(spq_pkg::CMD_PUSH, 32'h5555_5555));
    pending_items.push_back(make_item(spq_pkg::CMD_PUSH, 32'hAAAA_AAAA));
    pending_items.push_back(make_item(spq_pkg::CMD_PUSH, 32'h8000_0000));
    // fill the store, then push once more against a full store
    for (int i = 0; i < DEPTH - 6; i++)
      pending_items.push_back(make_item(spq_pkg::CMD_PUSH, random_key()));
    pending_items.push_back(make_item(spq_pkg::CMD_PUSH, 32'h1234_5678));
    for (int i = 0; i < 3; i++)
      pending_items.push_back(make_item(spq_pkg::CMD_POP, spq_pkg::KEY_W'($urandom)));

    // segments of varying push bias walk the occupancy between empty and full
    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      pending_items.push_back(make_item(
        ($urandom_range(99) < push_pct) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP,
        random_key()));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
